// ===== rtl/mseq_pkg.sv =====
// ----------------------------------------------------------------------------
// mseq_pkg
// Shared types and constants of the maneuver sequencer.
// ----------------------------------------------------------------------------
package mseq_pkg;

  localparam int unsigned ModeW  = 4;
  localparam int unsigned PosW   = 32;
  localparam int unsigned AngW   = 9;
  localparam int unsigned LenW   = 16;
  localparam int unsigned SpeedW = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 24;

  // mode codes
  localparam logic [ModeW-1:0] MODE_INIT      = 4'd0;
  localparam logic [ModeW-1:0] MODE_P_REL     = 4'd1;
  localparam logic [ModeW-1:0] MODE_U_PRESS   = 4'd2;
  localparam logic [ModeW-1:0] MODE_U_REL     = 4'd3;
  localparam logic [ModeW-1:0] MODE_DRIVE1    = 4'd4;
  localparam logic [ModeW-1:0] MODE_DRIVE2    = 4'd5;
  localparam logic [ModeW-1:0] MODE_DRIVE3    = 4'd6;
  localparam logic [ModeW-1:0] MODE_DRIVE4    = 4'd7;
  localparam logic [ModeW-1:0] MODE_TURN_R1   = 4'd8;
  localparam logic [ModeW-1:0] MODE_TURN_R2   = 4'd9;
  localparam logic [ModeW-1:0] MODE_TURN_L1   = 4'd10;
  localparam logic [ModeW-1:0] MODE_TURN_L2   = 4'd11;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_FIRST_TURN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FIRST_DRIVE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SECOND_TURN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SECOND_DRIVE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_THIRD_TURN   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_THIRD_DRIVE  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LAST_TURN    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FINAL_DRIVE  = 3'd7;

  localparam logic signed [SpeedW-1:0] SPEED_FULL = 9'sd200;
  localparam logic signed [SpeedW-1:0] SPEED_TURN = 9'sd100;
  localparam logic signed [SpeedW-1:0] SPEED_STOP = 9'sd0;

  typedef struct packed {
    logic [AngW-1:0] first_turn_angle;
    logic [LenW-1:0] first_drive_length;
    logic [AngW-1:0] second_turn_angle;
    logic [LenW-1:0] second_drive_length;
    logic [AngW-1:0] third_turn_angle;
    logic [LenW-1:0] third_drive_length;
    logic [AngW-1:0] last_turn_angle;
    logic [LenW-1:0] final_drive_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_turn_angle:    9'd79,
    first_drive_length:  16'd800,
    second_turn_angle:   9'd88,
    second_drive_length: 16'd1500,
    third_turn_angle:    9'd89,
    third_drive_length:  16'd1000,
    last_turn_angle:     9'd50,
    final_drive_length:  16'd9000
  };

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ModeW-1:0] resume_mode;
    logic [PosW-1:0]  distance_mark;
    logic [PosW-1:0]  angle_mark;
  } state_t;

  typedef struct packed {
    logic signed [PosW-1:0] net_distance;
    logic signed [PosW-1:0] net_angle;
    logic                   play_button;
    logic                   wall_seen;
    logic signed [15:0]     wall_strength;
    logic                   bump_left;
  } sense_t;

endpackage

// ===== rtl/maneuver_sequencer_with_pause_unit.sv =====
// ----------------------------------------------------------------------------
// maneuver_sequencer_with_pause_unit
// Pause-aware eight-step turn/drive sequencer giving wheel speeds per tick.
// ----------------------------------------------------------------------------
// One input word per control tick gives one output word with the left and
// right wheel speeds. Words pass an input register and an output register
// with the state update between them; a new word is taken every cycle while
// the output is not stalled. Both stages hold under backpressure. The user
// is to write thresholds through the cfg port only while no word is in
// flight; the block itself does not enforce it.
module maneuver_sequencer_with_pause_unit import mseq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // net_distance[31:0], net_angle[63:32], play_button[64], wall_seen[65],
  // wall_strength[81:66], bump_left[82], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // left_speed[8:0], right_speed[17:9], zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  cfg_t   cfg_q;
  state_t st_q, st_d;
  sense_t in_q;
  logic   in_valid_q, out_valid_q;
  logic   advance;
  logic signed [SpeedW-1:0] left_d, right_d, left_q, right_q;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIRST_TURN:   cfg_q.first_turn_angle    <= cfg_data_i[AngW-1:0];
        REG_FIRST_DRIVE:  cfg_q.first_drive_length  <= cfg_data_i;
        REG_SECOND_TURN:  cfg_q.second_turn_angle   <= cfg_data_i[AngW-1:0];
        REG_SECOND_DRIVE: cfg_q.second_drive_length <= cfg_data_i;
        REG_THIRD_TURN:   cfg_q.third_turn_angle    <= cfg_data_i[AngW-1:0];
        REG_THIRD_DRIVE:  cfg_q.third_drive_length  <= cfg_data_i;
        REG_LAST_TURN:    cfg_q.last_turn_angle     <= cfg_data_i[AngW-1:0];
        REG_FINAL_DRIVE:  cfg_q.final_drive_length  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mseq_core u_core (
    .cfg_i         (cfg_q),
    .st_i          (st_q),
    .in_i          (in_q),
    .st_o          (st_d),
    .left_speed_o  (left_d),
    .right_speed_o (right_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{mode: MODE_INIT, resume_mode: MODE_DRIVE1,
                       distance_mark: '0, angle_mark: '0};
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.net_distance  <= s_axis_tdata_i[31:0];
      in_q.net_angle     <= s_axis_tdata_i[63:32];
      in_q.play_button   <= s_axis_tdata_i[64];
      in_q.wall_seen     <= s_axis_tdata_i[65];
      in_q.wall_strength <= s_axis_tdata_i[81:66];
      in_q.bump_left     <= s_axis_tdata_i[82];
    end
    if (advance && in_valid_q) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, right_q, left_q};

endmodule

// ===== rtl/mseq_core.sv =====
// ----------------------------------------------------------------------------
// mseq_core
// Next-state and wheel speed logic for one control tick.
// ----------------------------------------------------------------------------
module mseq_core import mseq_pkg::*; (
  input  cfg_t                     cfg_i,
  input  state_t                   st_i,
  input  sense_t                   in_i,
  output state_t                   st_o,
  output logic signed [SpeedW-1:0] left_speed_o,
  output logic signed [SpeedW-1:0] right_speed_o
);

  logic [PosW-1:0] dist_diff, ang_diff, dd, da;
  logic            trig;

  assign dist_diff = in_i.net_distance - st_i.distance_mark;
  assign ang_diff  = in_i.net_angle - st_i.angle_mark;
  assign dd = dist_diff[PosW-1] ? (PosW'(0) - dist_diff) : dist_diff;
  assign da = ang_diff[PosW-1]  ? (PosW'(0) - ang_diff)  : ang_diff;

  assign trig = (in_i.wall_seen && !in_i.wall_strength[15]) || in_i.bump_left;

  always_comb begin
    st_o = st_i;
    if (st_i.mode <= MODE_U_REL || in_i.play_button) begin
      case (st_i.mode)
        MODE_INIT:    st_o.mode = MODE_U_PRESS;
        MODE_P_REL:   if (!in_i.play_button) st_o.mode = MODE_U_PRESS;
        MODE_U_PRESS: if (in_i.play_button) st_o.mode = MODE_U_REL;
        MODE_U_REL:   if (!in_i.play_button) st_o.mode = st_i.resume_mode;
        default: begin
          st_o.resume_mode = st_i.mode;
          st_o.mode        = MODE_P_REL;
        end
      endcase
    end else if (trig) begin
      st_o.angle_mark    = in_i.net_angle;
      st_o.distance_mark = in_i.net_distance;
      st_o.mode          = MODE_TURN_R1;
    end else if (st_i.mode == MODE_TURN_R1 &&
                 da >= PosW'(cfg_i.first_turn_angle)) begin
      st_o.angle_mark    = in_i.net_angle;
      st_o.distance_mark = in_i.net_distance;
      st_o.mode          = MODE_DRIVE1;
    end else if (st_i.mode == MODE_DRIVE1 &&
                 dd >= PosW'(cfg_i.first_drive_length)) begin
      st_o.angle_mark    = in_i.net_angle;
      st_o.distance_mark = in_i.net_distance;
      st_o.mode          = MODE_TURN_L1;
    end else if (st_i.mode == MODE_TURN_L1 &&
                 da >= PosW'(cfg_i.second_turn_angle)) begin
      st_o.angle_mark    = in_i.net_angle;
      st_o.distance_mark = in_i.net_distance;
      st_o.mode          = MODE_DRIVE2;
    end else if (st_i.mode == MODE_DRIVE2 &&
                 dd >= PosW'(cfg_i.second_drive_length)) begin
      st_o.angle_mark    = in_i.net_angle;
      st_o.distance_mark = in_i.net_distance;
      st_o.mode          = MODE_TURN_L2;
    end else if (st_i.mode == MODE_TURN_L2 &&
                 da >= PosW'(cfg_i.third_turn_angle)) begin
      st_o.angle_mark    = in_i.net_angle;
      st_o.distance_mark = in_i.net_distance;
      st_o.mode          = MODE_DRIVE3;
    end else if (st_i.mode == MODE_DRIVE3 &&
                 dd >= PosW'(cfg_i.third_drive_length)) begin
      st_o.distance_mark = in_i.net_distance;
      st_o.mode          = MODE_TURN_R2;
    end else if (st_i.mode == MODE_TURN_R2 &&
                 da >= PosW'(cfg_i.last_turn_angle)) begin
      st_o.distance_mark = in_i.net_distance;
      st_o.mode          = MODE_DRIVE4;
    end else if (st_i.mode == MODE_DRIVE4 &&
                 dd >= PosW'(cfg_i.final_drive_length)) begin
      st_o.distance_mark = in_i.net_distance;
    end
  end

  always_comb begin
    unique case (st_o.mode) inside
      MODE_DRIVE1, MODE_DRIVE2, MODE_DRIVE3, MODE_DRIVE4: begin
        left_speed_o  = SPEED_FULL;
        right_speed_o = SPEED_FULL;
      end
      MODE_TURN_R1, MODE_TURN_R2: begin
        left_speed_o  = SPEED_TURN;
        right_speed_o = -SPEED_TURN;
      end
      MODE_TURN_L1, MODE_TURN_L2: begin
        left_speed_o  = -SPEED_TURN;
        right_speed_o = SPEED_TURN;
      end
      default: begin
        left_speed_o  = SPEED_STOP;
        right_speed_o = SPEED_STOP;
      end
    endcase
  end

endmodule

// ===== rtl/mseq_checker.sv =====
// ----------------------------------------------------------------------------
// mseq_checker
// Port-level checks of the maneuver sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mseq_checker import mseq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic signed [SpeedW-1:0] left, right;
  assign left  = m_axis_tdata_o[8:0];
  assign right = m_axis_tdata_o[17:9];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

  a_speed_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (left == SPEED_STOP && right == SPEED_STOP) ||
      (left == SPEED_FULL && right == SPEED_FULL) ||
      (left == SPEED_TURN && right == -SPEED_TURN) ||
      (left == -SPEED_TURN && right == SPEED_TURN))
    else $error("wheel speed pair not a valid maneuver");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[23:18] == 6'd0)
    else $error("output pad bits not zero");

endmodule

bind maneuver_sequencer_with_pause_unit mseq_checker u_mseq_checker (.*);
